FILE: design/icp_pkg.sv
// Shared types and constants for the IPv4 dotted-quad/CIDR text parser.
// No dependencies; imported by icp_result and ipv4_cidr_text_parser_top.
package icp_pkg;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [8:0] OCTET_SAT  = 9'd511;
  localparam logic [5:0] PREFIX_SAT = 6'd63;
  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [5:0] PREFIX_MAX = 6'd32;
  localparam logic [5:0] ADDR_BITS  = 6'd32;

  localparam logic [2:0] FIELD_OCTET3 = 3'd3;
  localparam logic [2:0] FIELD_PREFIX = 3'd4;

  localparam logic OP_GATEWAY = 1'b0;
  localparam logic OP_ADDRESS = 1'b1;

  typedef struct packed {
    logic [3:0][8:0] octet;
    logic [5:0]      prefix;
    logic [2:0]      field;
    logic            failed;
  } icp_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [31:0] broadcast;
  } icp_result_t;

  // acc * 10 + digit on a 9-bit accumulator, widened so nothing is lost
  function automatic logic [12:0] mul10_add(input logic [8:0] acc, input logic [3:0] d);
    mul10_add = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {9'd0, d};
  endfunction

endpackage

FILE: design/icp_result.sv
// Final validation and address/netmask/broadcast formation for one string.
// Depends on icp_pkg.
module icp_result (
  input  logic             op,
  input  icp_pkg::icp_state_t st,
  output icp_pkg::icp_result_t res
);
  import icp_pkg::*;

  logic        ok;
  logic [31:0] addr;
  logic [31:0] mask;
  logic [5:0]  shamt;

  always_comb begin
    ok = !st.failed;
    if (st.field != ((op == OP_ADDRESS) ? FIELD_PREFIX : FIELD_OCTET3)) begin
      ok = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      if (st.octet[i] > OCTET_MAX) begin
        ok = 1'b0;
      end
    end
    if (op == OP_ADDRESS && (st.prefix == '0 || st.prefix > PREFIX_MAX)) begin
      ok = 1'b0;
    end

    addr  = {st.octet[0][7:0], st.octet[1][7:0], st.octet[2][7:0], st.octet[3][7:0]};
    shamt = ADDR_BITS - st.prefix;
    mask  = 32'hFFFF_FFFF << shamt;

    res.ok        = ok;
    res.address   = ok ? addr : '0;
    res.netmask   = (ok && op == OP_ADDRESS) ? mask : '0;
    res.broadcast = (ok && op == OP_ADDRESS) ? (addr | ~mask) : '0;
  end

endmodule

FILE: design/ipv4_cidr_text_parser_top.sv
// Top level of the IPv4 dotted-quad/CIDR text parser.
// Depends on icp_pkg and icp_result.
//
// Takes one ASCII character per item and returns one result item per string,
// on the character marked with in_tlast. Each character passes through an
// input register, then combinational parse and validation logic into the
// result register, which drives the output. One character is accepted
// every cycle; the input stalls only
// when a finished result is still held in the result register and the next
// string end arrives. in_tuser selects the form: 0 = x.x.x.x, 1 = x.x.x.x/yy.
module ipv4_cidr_text_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] op
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] address, [63:32] netmask, [95:64] broadcast
  output logic        out_tuser   // [0] ok
);
  import icp_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic        in_op_r;
  logic [7:0]  in_ch_r;
  logic        in_last_r;
  icp_state_t  state_r, state_nxt, st_step;
  logic        out_valid_r, out_valid_nxt;
  icp_result_t out_res_r, res;
  logic        proc_go;
  logic [3:0]  digit;
  logic [12:0] oct_wide [4];
  logic [12:0] pre_wide;

  assign proc_go   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_go;
  assign in_valid_nxt = (in_valid_r && !proc_go) || (in_tvalid && in_tready);
  assign out_valid_nxt = (out_valid_r && !out_tready) || (proc_go && in_last_r);

  always_comb begin
    st_step  = state_r;
    digit    = 4'(in_ch_r - CH_ZERO);
    pre_wide = mul10_add({3'b000, state_r.prefix}, digit);
    for (int i = 0; i < 4; i++) begin
      oct_wide[i] = mul10_add(state_r.octet[i], digit);
    end
    if (!state_r.failed) begin
      if (in_ch_r == CH_DOT && state_r.field < FIELD_OCTET3) begin
        st_step.field = state_r.field + 3'd1;
      end else if (in_ch_r == CH_SLASH && in_op_r == OP_ADDRESS &&
                   state_r.field == FIELD_OCTET3) begin
        st_step.field = FIELD_PREFIX;
      end else if (in_ch_r >= CH_ZERO && in_ch_r <= CH_NINE) begin
        if (state_r.field < FIELD_PREFIX) begin
          for (int i = 0; i < 4; i++) begin
            if (state_r.field[1:0] == 2'(i)) begin
              st_step.octet[i] = (oct_wide[i] > 13'(OCTET_SAT)) ? OCTET_SAT
                                                              : oct_wide[i][8:0];
            end
          end
        end else begin
          st_step.prefix = (pre_wide > 13'(PREFIX_SAT)) ? PREFIX_SAT : pre_wide[5:0];
        end
      end else begin
        st_step.failed = 1'b1;
      end
    end
    state_nxt = state_r;
    if (proc_go) begin
      state_nxt = in_last_r ? '0 : st_step;
    end
  end

  icp_result u_result (
    .op  (in_op_r),
    .st  (st_step),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_ch_r   <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (proc_go && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = {out_res_r.broadcast, out_res_r.netmask, out_res_r.address};

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && in_last_r |=> state_r == '0)
    else $error("parser state not cleared after string end");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.failed && proc_go && !in_last_r |=> state_r.failed)
    else $error("failure flag dropped mid-string");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed result carries nonzero data");

  a_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_res_r.netmask != '0 |->
      out_res_r.broadcast == (out_res_r.address | ~out_res_r.netmask))
    else $error("broadcast inconsistent with address and netmask");
`endif

endmodule
